@@ hw/rtl/fps_pkg.sv @@
// ----------------------------------------------------------------------------
// fps_pkg
// Shared widths, operation codes and the command and status bundles that
// pass between the prefix sum table controller and its datapath.
// ----------------------------------------------------------------------------
package fps_pkg;

	localparam int IDX_W  = 11;
	localparam int SUM_W  = 64;
	// A walk node may step one lowest set bit past an 11-bit size.
	localparam int NODE_W = 12;

	localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic walk;
		logic out_load;
	} fps_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic node_ok;
		logic is_query;
	} fps_status_t;

endpackage

@@ hw/rtl/fenwick_prefix_sum_table.sv @@
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table
// Binary indexed tree of 64-bit counters with point update and prefix query.
// ----------------------------------------------------------------------------
// After reset the block clears its ENTRIES-word store, one word a cycle, and
// holds in_stall high until the clearing pass ends; size writes are taken during
// that time. Each transaction then walks the tree with one memory read per
// node, updates writing the new partial sum back in the cycle after the read.
// A transaction is accepted only in the idle state, so the next one waits
// until the walk and its done step have finished; an update at index zero or
// beyond the size visits no node. A query result waits in an output register,
// and the next transaction may run while it is held, but a following query
// result waits until it is taken.
module fenwick_prefix_sum_table #(
	parameter int ENTRIES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [fps_pkg::IDX_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [fps_pkg::IDX_W-1:0] index,
	input  logic [fps_pkg::SUM_W-1:0] addend,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [fps_pkg::SUM_W-1:0] prefix_sum
);

	fps_pkg::fps_cmd_t    cmd;
	fps_pkg::fps_status_t status;

	fps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	fps_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.operation  (operation),
		.index      (index),
		.addend     (addend),
		.prefix_sum (prefix_sum),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

@@ hw/rtl/fps_ctrl.sv @@
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer for the prefix sum table: runs the clearing pass after reset,
// accepts one transaction at a time, steps the tree walk and hands query
// results to the output register.
// ----------------------------------------------------------------------------
module fps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  fps_pkg::fps_status_t status,
	output fps_pkg::fps_cmd_t   cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (!status.node_ok) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.is_query) begin
					state_next = ST_IDLE;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is only produced at the end of a query walk.
	a_out_load_query: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (state_q == ST_DONE) && status.is_query)
		else $error("result loaded outside a finished query");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && !status.node_ok |=> (state_q == ST_DONE))
		else $error("walk did not finish when the node ran out of range");

	a_load_walks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_WALK))
		else $error("accepted transaction did not start a walk");

endmodule

@@ hw/rtl/fps_dp.sv @@
// ----------------------------------------------------------------------------
// fps_dp
// Datapath of the prefix sum table: size register, node walker, the
// partial sum memory with a registered read, the read-modify-write path
// for updates, the query accumulator and the result register.
// ----------------------------------------------------------------------------
module fps_dp #(
	parameter int ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [fps_pkg::IDX_W-1:0]    cfg_wdata,
	input  logic                         operation,
	input  logic [fps_pkg::IDX_W-1:0]    index,
	input  logic [fps_pkg::SUM_W-1:0]    addend,
	output logic [fps_pkg::SUM_W-1:0]    prefix_sum,
	input  fps_pkg::fps_cmd_t            cmd,
	output fps_pkg::fps_status_t         status
);

	localparam int AW  = $clog2(ENTRIES);
	localparam int CAP = (ENTRIES < 2047) ? ENTRIES : 2047;
	localparam logic [fps_pkg::IDX_W-1:0] SIZE_CAP = fps_pkg::IDX_W'(CAP);
	localparam logic [AW-1:0] CLR_LAST = AW'(ENTRIES - 1);

	logic [fps_pkg::SUM_W-1:0]  mem [ENTRIES];

	logic [fps_pkg::IDX_W-1:0]  entries_in_use_q;
	logic [fps_pkg::IDX_W-1:0]  size_now;
	logic [fps_pkg::IDX_W-1:0]  idx_clamped;
	logic                       op_q;
	logic [fps_pkg::NODE_W-1:0] node_q;
	logic [fps_pkg::NODE_W-1:0] node_low;
	logic [fps_pkg::NODE_W-1:0] node_next;
	logic [fps_pkg::NODE_W-1:0] node_start;
	logic [fps_pkg::SUM_W-1:0]  addend_q;
	logic [fps_pkg::SUM_W-1:0]  sum_q;
	logic [fps_pkg::SUM_W-1:0]  prefix_sum_q;
	logic [fps_pkg::SUM_W-1:0]  rdata_s1;
	logic [AW-1:0]              addr_s1;
	logic                       rd_valid_s1;
	logic [AW-1:0]              clr_addr_q;
	logic [AW-1:0]              raddr;
	logic                       node_ok;
	logic                       rd_en;
	logic                       upd_we;

	// Sizes above the store behave as the store size.
	assign size_now    = (entries_in_use_q > SIZE_CAP) ? SIZE_CAP : entries_in_use_q;
	assign idx_clamped = (index > size_now) ? size_now : index;
	assign node_start  = (operation == fps_pkg::OP_UPDATE) ? {1'b0, index}
	                                                       : {1'b0, idx_clamped};

	assign node_ok   = (node_q != '0) && (node_q <= {1'b0, size_now});
	assign node_low  = node_q & (~node_q + fps_pkg::NODE_W'(1));
	assign node_next = (op_q == fps_pkg::OP_UPDATE) ? (node_q + node_low)
	                                                : (node_q - node_low);
	assign rd_en     = cmd.walk && node_ok;
	assign raddr     = AW'(node_q - fps_pkg::NODE_W'(1));
	assign upd_we    = rd_valid_s1 && (op_q == fps_pkg::OP_UPDATE);

	assign status.clear_last = (clr_addr_q == CLR_LAST);
	assign status.node_ok    = node_ok;
	assign status.is_query   = (op_q == fps_pkg::OP_QUERY);

	assign prefix_sum = prefix_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= fps_pkg::SIZE_RESET;
			clr_addr_q       <= '0;
			rd_valid_s1      <= 1'b0;
		end else begin
			if (cfg_wen) begin
				entries_in_use_q <= cfg_wdata;
			end
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			node_q   <= node_start;
			addend_q <= addend;
		end else if (rd_en) begin
			node_q <= node_next;
		end
		if (rd_en) begin
			addr_s1 <= raddr;
		end
		if (cmd.load) begin
			sum_q <= '0;
		end else if (rd_valid_s1 && (op_q == fps_pkg::OP_QUERY)) begin
			sum_q <= sum_q + rdata_s1;
		end
		if (cmd.out_load) begin
			prefix_sum_q <= sum_q;
		end
	end

	// Partial sum store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem[clr_addr_q] <= '0;
		end else if (upd_we) begin
			mem[addr_s1] <= rdata_s1 + addend_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Nodes of one walk are distinct, so a read never meets the pending write.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && rd_valid_s1 |-> (raddr != addr_s1))
		else $error("read and write of the same node in one cycle");

	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !upd_we && !rd_en)
		else $error("tree access during the clearing pass");

endmodule

@@ tb/sv/tb_fenwick_prefix_sum_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fenwick_prefix_sum_table
// Self-checking bench for the binary indexed tree of 64-bit counters. A
// behavioral copy of the tree is kept beside the block and updated at every
// accepted input transaction; each query pushes its expected prefix sum, and
// every accepted result is compared with the oldest one. Directed cases cover
// the cleared store, wrapping sums and the ignored updates; random phases run
// across several tree sizes, including zero and sizes above the store.
// ----------------------------------------------------------------------------
module tb_fenwick_prefix_sum_table;

	localparam int STORE_DEPTH  = 1024;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 100;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_wen;
	logic [fps_pkg::IDX_W-1:0] cfg_wdata;
	logic                      in_valid;
	logic                      in_stall;
	logic                      operation;
	logic [fps_pkg::IDX_W-1:0] index;
	logic [fps_pkg::SUM_W-1:0] addend;
	logic                      out_valid;
	logic                      out_stall;
	logic [fps_pkg::SUM_W-1:0] prefix_sum;

	// Behavioral copy of the tree and its size register.
	bit   [fps_pkg::SUM_W-1:0] node_sums [1:STORE_DEPTH];
	logic [fps_pkg::IDX_W-1:0] size_setting;
	bit   [fps_pkg::SUM_W-1:0] expected_sums [$];

	int error_count;
	bit in_quiet;
	bit out_quiet;
	bit hold_request;

	fenwick_prefix_sum_table #(
		.ENTRIES(STORE_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.index     (index),
		.addend    (addend),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.prefix_sum(prefix_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what,
			input logic [fps_pkg::SUM_W-1:0] got,
			input logic [fps_pkg::SUM_W-1:0] want);
		$display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Apply one accepted transaction to the tree copy.
	task automatic predict_item(input logic op, input logic [fps_pkg::IDX_W-1:0] idx,
			input logic [fps_pkg::SUM_W-1:0] val);
		int unsigned limit;
		int unsigned node;
		bit [fps_pkg::SUM_W-1:0] acc;
		limit = (size_setting > STORE_DEPTH) ? STORE_DEPTH : 32'(size_setting);
		node  = 32'(idx);
		acc   = '0;
		if (op == fps_pkg::OP_UPDATE) begin
			// Index zero and indices past the size never start the walk.
			if (node != 0) begin
				while (node <= limit) begin
					node_sums[node] += val;
					node += node & (~node + 1);
				end
			end
		end else begin
			if (node > limit)
				node = limit;
			while (node > 0) begin
				acc += node_sums[node];
				node -= node & (~node + 1);
			end
			expected_sums = {expected_sums, acc};
		end
	endtask

	task automatic send_item(input logic op, input logic [fps_pkg::IDX_W-1:0] idx,
			input logic [fps_pkg::SUM_W-1:0] val);
		if (!in_quiet) begin
			while ($urandom_range(0, 99) < 37) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		operation <= op;
		index     <= idx;
		addend    <= val;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predict_item(op, idx, val);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		// Updates give no result, so let the last walk finish.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [fps_pkg::IDX_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen      <= 1'b0;
		size_setting = value;
	endtask

	function automatic logic [fps_pkg::SUM_W-1:0] random_addend();
		case ($urandom_range(0, 3))
			0: return fps_pkg::SUM_W'($urandom_range(0, 15));
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Mostly indices around the size in use, sometimes anywhere in the field.
	function automatic logic [fps_pkg::IDX_W-1:0] random_index();
		int unsigned limit;
		limit = (size_setting > STORE_DEPTH) ? STORE_DEPTH : 32'(size_setting);
		if ($urandom_range(0, 9) < 7)
			return fps_pkg::IDX_W'($urandom_range(0, limit + 1));
		return fps_pkg::IDX_W'($urandom_range(0, (1 << fps_pkg::IDX_W) - 1));
	endfunction

	task automatic send_random_item();
		logic op;
		op = ($urandom_range(0, 1) == 1) ? fps_pkg::OP_UPDATE : fps_pkg::OP_QUERY;
		send_item(op, random_index(), random_addend());
	endtask

	task automatic test_cleared_store();
		send_item(fps_pkg::OP_QUERY, 11'd0, '1);
		send_item(fps_pkg::OP_QUERY, 11'd1, '0);
		send_item(fps_pkg::OP_QUERY, 11'd700, '0);
		send_item(fps_pkg::OP_QUERY, 11'd1024, '0);
		send_item(fps_pkg::OP_QUERY, 11'd2047, '1);
	endtask

	task automatic test_update_extremes();
		send_item(fps_pkg::OP_UPDATE, 11'd1, '1);
		send_item(fps_pkg::OP_UPDATE, 11'd1, '1);
		send_item(fps_pkg::OP_UPDATE, 11'd1024, 64'h8000_0000_0000_0000);
		send_item(fps_pkg::OP_UPDATE, 11'd0, 64'd5);
		send_item(fps_pkg::OP_UPDATE, 11'd2047, 64'd7);
		send_item(fps_pkg::OP_UPDATE, 11'd1025, 64'd9);
		send_item(fps_pkg::OP_UPDATE, 11'd1023, 64'd1);
		send_item(fps_pkg::OP_UPDATE, 11'd512, '0);
		send_item(fps_pkg::OP_QUERY, 11'd0, '0);
		send_item(fps_pkg::OP_QUERY, 11'd1, '0);
		send_item(fps_pkg::OP_QUERY, 11'd512, '0);
		send_item(fps_pkg::OP_QUERY, 11'd1023, '0);
		send_item(fps_pkg::OP_QUERY, 11'd1024, '0);
		send_item(fps_pkg::OP_QUERY, 11'd1025, '0);
		send_item(fps_pkg::OP_QUERY, 11'd2047, '0);
	endtask

	task automatic test_random_sizes();
		int phase;
		int item;
		logic [fps_pkg::IDX_W-1:0] next_size;
		for (phase = 0; phase < 12; phase++) begin
			case (phase)
				0: next_size = fps_pkg::SIZE_RESET;
				1: next_size = 11'd1;
				2: next_size = 11'd0;
				3: next_size = 11'd2047;
				4: next_size = 11'd2;
				5: next_size = fps_pkg::SIZE_RESET;
				6: next_size = 11'd17;
				default: next_size = fps_pkg::IDX_W'($urandom_range(1, STORE_DEPTH));
			endcase
			drain();
			write_size(next_size);
			// One phase runs with both sides streaming back to back.
			in_quiet  = (phase == 5);
			out_quiet = (phase == 5);
			for (item = 0; item < PHASE_ITEMS; item++)
				send_random_item();
		end
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
	endtask

	task automatic test_output_backpressure();
		int item;
		drain();
		write_size(fps_pkg::SIZE_RESET);
		hold_request = 1'b1;
		in_quiet     = 1'b1;
		for (item = 0; item < 40; item++) begin
			if (item % 4 == 0)
				send_item(fps_pkg::OP_UPDATE, random_index(), random_addend());
			else
				send_item(fps_pkg::OP_QUERY, random_index(), '0);
		end
		in_quiet = 1'b0;
	endtask

	// Receiver: random stalls, a quiet mode, and one long hold on request.
	initial begin : result_receiver
		int held;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			if (out_quiet)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 37);
		end
	end

	always @(posedge clk) begin : result_check
		logic [fps_pkg::SUM_W-1:0] want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_sums.size() == 0) begin
				report_mismatch("result with no query waiting", prefix_sum, '0);
			end else begin
				want = expected_sums.pop_front();
				if (prefix_sum !== want)
					report_mismatch("prefix_sum", prefix_sum, want);
			end
		end
	end

	initial begin : run_tests
		int waited;
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_wdata    = fps_pkg::SIZE_RESET;
		in_valid     = 1'b0;
		operation    = fps_pkg::OP_QUERY;
		index        = '0;
		addend       = '0;
		in_quiet     = 1'b0;
		out_quiet    = 1'b0;
		hold_request = 1'b0;
		size_setting = fps_pkg::SIZE_RESET;
		error_count  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_cleared_store();
		test_update_extremes();
		test_random_sizes();
		test_output_backpressure();

		in_valid <= 1'b0;
		for (waited = 0; waited < 5000 && expected_sums.size() != 0; waited++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0)
			report_mismatch("queries left without a result",
				fps_pkg::SUM_W'(expected_sums.size()), '0);

		if (error_count == 0)
			$display("fenwick_prefix_sum_table verification clean");
		else
			$display("fenwick_prefix_sum_table verification failed");
		$finish;
	end

	initial begin : run_limit
		#5_000_000;
		$display("fenwick_prefix_sum_table verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/fps_pkg.sv
hw/rtl/fps_ctrl.sv
hw/rtl/fps_dp.sv
hw/rtl/fenwick_prefix_sum_table.sv
tb/sv/tb_fenwick_prefix_sum_table.sv
